@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Check a property during reset as well
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`endif

@@ hdl/ddo_pkg.sv @@
package ddo_pkg;

   localparam int CordicSteps = 16;
   localparam int AngleTableLen = 30;
   localparam int StepW = $clog2(CordicSteps + 1);
   localparam logic [31:0] CordicStart = 32'd652032874;
   localparam logic [31:0] InvTwoPiQ32 = 32'd683565276;
   localparam logic [31:0] InvSepReset = 32'd145635;
   localparam logic [31:0] VelReset = 32'd655;
   localparam logic [31:0] RateReset = 32'd66;

   localparam logic OP_ENCODER = 1'b0;
   localparam logic OP_INTEGRATE = 1'b1;

   localparam logic REG_DISTANCE_SCALE = 1'b0;
   localparam logic REG_INV_SEPARATION = 1'b1;

   typedef struct packed {
      logic operation;
      logic signed [15:0] left_ticks;
      logic signed [15:0] right_ticks;
      logic [23:0] elapsed_time;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [31:0] heading;
      logic signed [31:0] forward_velocity;
      logic signed [31:0] turn_rate;
      logic [31:0] step_number;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ENC_MUL,
      ST_ENC_ROT,
      ST_ENC_FIN,
      ST_ENC_HI,
      ST_CORDIC_START,
      ST_CORDIC_RUN,
      ST_MUL_XA,
      ST_MUL_XB,
      ST_MUL_YA,
      ST_MUL_YB,
      ST_YAW_A,
      ST_YAW_B,
      ST_YAW_C,
      ST_FIN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic [31:0] angle;
   } cordic_cmd_type;

   typedef struct packed {
      logic done;
      logic signed [33:0] sin_val;
      logic signed [33:0] cos_val;
   } cordic_res_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] i);
      logic [31:0] r;
      case (i)
         5'd0: r = 32'd536870912;
         5'd1: r = 32'd316933406;
         5'd2: r = 32'd167458907;
         5'd3: r = 32'd85004756;
         5'd4: r = 32'd42667331;
         5'd5: r = 32'd21354465;
         5'd6: r = 32'd10679838;
         5'd7: r = 32'd5340245;
         5'd8: r = 32'd2670163;
         5'd9: r = 32'd1335087;
         5'd10: r = 32'd667544;
         5'd11: r = 32'd333772;
         5'd12: r = 32'd166886;
         5'd13: r = 32'd83443;
         5'd14: r = 32'd41722;
         5'd15: r = 32'd20861;
         5'd16: r = 32'd10430;
         5'd17: r = 32'd5215;
         5'd18: r = 32'd2608;
         5'd19: r = 32'd1304;
         5'd20: r = 32'd652;
         5'd21: r = 32'd326;
         5'd22: r = 32'd163;
         5'd23: r = 32'd81;
         5'd24: r = 32'd41;
         5'd25: r = 32'd20;
         5'd26: r = 32'd10;
         5'd27: r = 32'd5;
         5'd28: r = 32'd3;
         5'd29: r = 32'd1;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

@@ hdl/ddo_cordic.sv @@
`include "assert_macros.svh"

module ddo_cordic (
   input  logic                    clock,
   input  logic                    reset,
   input  ddo_pkg::cordic_cmd_type cmd,
   output ddo_pkg::cordic_res_type res
);
   import ddo_pkg::*;

   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic signed [33:0] z_ff, z_in;
   logic [StepW-1:0] step_ff, step_in;
   logic busy_ff, busy_in, flip_ff, flip_in, done_ff, done_in;
   logic [31:0] a_rot;
   logic signed [33:0] xs, ys, at;

   always_comb begin
      a_rot = cmd.angle ^ {cmd.angle[31] ^ cmd.angle[30], 31'd0};
      xs = x_ff >>> step_ff;
      ys = y_ff >>> step_ff;
      at = $signed({2'b00, atan_entry(5'(step_ff))});
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      flip_in = flip_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         x_in = $signed({2'b00, CordicStart});
         y_in = '0;
         z_in = 34'(signed'(a_rot));
         step_in = '0;
         busy_in = 1'b1;
         flip_in = cmd.angle[31] ^ cmd.angle[30];
      end else if (busy_ff) begin
         // one rotation per cycle
         if (!z_ff[33]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == StepW'(CordicSteps - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      step_ff <= step_in;
      flip_ff <= flip_in;
   end

   assign res.done = done_ff;
   assign res.sin_val = flip_ff ? -y_ff : y_ff;
   assign res.cos_val = flip_ff ? -x_ff : x_ff;

   `ASSERT_CLK(a_done_not_busy, clock, reset, done_ff |-> !busy_ff)
   `ASSERT_CLK(a_done_after_busy, clock, reset, done_ff |-> $past(busy_ff))
   `ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !busy_ff && !done_ff)

endmodule

@@ hdl/ddo_serial_mul.sv @@
`include "assert_macros.svh"

// Shift-and-add multiplier, one multiplier bit per cycle, 40 x 64 bits
module ddo_serial_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] mcand,
   input  logic [39:0] mplier,
   output logic [103:0] product,
   output logic        done
);
   import ddo_pkg::*;

   logic [103:0] acc_ff, acc_in;
   logic [103:0] mc_ff, mc_in;
   logic [39:0] mp_ff, mp_in;
   logic busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      acc_in = acc_ff;
      mc_in = mc_ff;
      mp_in = mp_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in = '0;
         mc_in = {40'd0, mcand};
         mp_in = mplier;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (mp_ff[0]) acc_in = acc_ff + mc_ff;
         mc_in = mc_ff << 1;
         mp_in = mp_ff >> 1;
         // stop once remaining multiplier bits are zero
         if (mp_ff[39:1] == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      mc_ff <= mc_in;
      mp_ff <= mp_in;
   end

   assign product = acc_ff;
   assign done = done_ff;

   `ASSERT_CLK(a_mul_done_pulse, clock, reset, done_ff |=> !done_ff || $past(start, 1))
   `ASSERT_CLK(a_mul_exclusive, clock, reset, !(done_ff && busy_ff))

endmodule

@@ hdl/diff_drive_odometry_core.sv @@
// An encoder transaction runs four serial products in turn; an integrate transaction
// runs one CORDIC pass of CordicSteps rotations, then seven serial products.
// Each serial multiplier stops after the highest set bit of its multiplier word;
// the CORDIC unit does one rotation a cycle.
// Throughput: one transaction in flight; the next can be accepted in the cycle after the result leaves.
// Reset: synchronous, active high; pose, counter zero, velocity 655, yaw rate 66.
`include "assert_macros.svh"

module diff_drive_odometry_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ddo_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ddo_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic             csr_index,
   input  logic [31:0]      csr_data
);
   import ddo_pkg::*;

   state_type state_ff, state_in;
   logic [31:0] scale_ff, invsep_ff;
   logic signed [31:0] x_ff, x_in, y_ff, y_in, vel_ff, vel_in, rate_ff, rate_in;
   logic [31:0] yaw_ff, yaw_in, cnt_ff, cnt_in, num_ff, num_in;
   req_type item_ff;
   logic [63:0] tmp_ff, tmp_in;
   logic [31:0] hold_ff, hold_in;
   rsp_type out_ff;
   logic out_load;

   cordic_cmd_type ccmd;
   cordic_res_type cres;
   logic signed [33:0] sn_ff, cs_ff;

   logic mstart;
   logic [63:0] mcand;
   logic [39:0] mplier;
   logic [103:0] prod;
   logic mdone;

   ddo_cordic u_cordic (.clock(clock), .reset(reset), .cmd(ccmd), .res(cres));
   ddo_serial_mul u_mul (.clock(clock), .reset(reset), .start(mstart), .mcand(mcand),
      .mplier(mplier), .product(prod), .done(mdone));

   logic accept;
   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data = out_ff;

   logic signed [16:0] sum_w, diff_w;
   logic [16:0] sum_m, diff_m;
   logic [23:0] dt;
   logic [31:0] vmag;
   logic [33:0] sn_m, cs_m;
   logic [63:0] rr;

   function automatic logic signed [31:0] sat_mag(input logic [63:0] m, input logic neg);
      logic signed [31:0] r;
      if (neg) r = (m >= 64'h80000000) ? 32'sh80000000 : -$signed(m[31:0]);
      else r = (m >= 64'h7fffffff) ? 32'sh7fffffff : $signed(m[31:0]);
      return r;
   endfunction

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
      input logic [63:0] m, input logic neg);
      logic signed [33:0] d, s;
      // any step of 2^32 or more saturates whatever a is
      d = (m > 64'h0ffffffff) ? 34'sh0ffffffff : $signed({1'b0, m[32:0]});
      if (neg) d = -d;
      s = 34'(a) + d;
      if (s > 34'sh7fffffff) return 32'sh7fffffff;
      else if (s < -34'sh80000000) return 32'sh80000000;
      return s[31:0];
   endfunction

   always_comb begin
      sum_w = 17'(item_ff.left_ticks) + 17'(item_ff.right_ticks);
      diff_w = 17'(item_ff.right_ticks) - 17'(item_ff.left_ticks);
      sum_m = sum_w[16] ? 17'(-sum_w) : 17'(sum_w);
      diff_m = diff_w[16] ? 17'(-diff_w) : 17'(diff_w);
      dt = (cnt_ff == '0) ? 24'd0 : item_ff.elapsed_time;
      vmag = vel_ff[31] ? 32'(-vel_ff) : 32'(vel_ff);
      sn_m = cres.sin_val[33] ? 34'(-cres.sin_val) : 34'(cres.sin_val);
      cs_m = cs_ff[33] ? 34'(-cs_ff) : 34'(cs_ff);
      rr = '0;
      state_in = state_ff;
      x_in = x_ff; y_in = y_ff; yaw_in = yaw_ff; vel_in = vel_ff; rate_in = rate_ff;
      cnt_in = cnt_ff; num_in = num_ff; tmp_in = tmp_ff; hold_in = hold_ff;
      ccmd.start = 1'b0; ccmd.angle = yaw_ff;
      mstart = 1'b0; mcand = '0; mplier = '0;
      out_load = 1'b0;
      case (state_ff)
         ST_IDLE: if (accept) begin
            num_in = cnt_ff;
            state_in = req_data.operation == OP_ENCODER ? ST_ENC_MUL : ST_CORDIC_START;
         end
         ST_ENC_MUL: begin
            mstart = 1'b1; mcand = {32'd0, scale_ff}; mplier = {23'd0, sum_m};
            state_in = ST_ENC_ROT;
         end
         ST_ENC_ROT: if (mdone) begin
            vel_in = sat_mag({1'b0, prod[63:1]}, sum_w[16]);
            mstart = 1'b1; mcand = {32'd0, scale_ff}; mplier = {23'd0, diff_m};
            state_in = ST_ENC_FIN;
         end
         ST_ENC_FIN: if (mdone) begin
            // t split into hi/lo words times reciprocal, hi word first
            tmp_in = prod[63:0];
            mstart = 1'b1; mcand = {32'd0, prod[63:32]}; mplier = {8'd0, invsep_ff};
            state_in = ST_ENC_HI;
         end
         ST_ENC_HI: if (mdone) begin
            tmp_in = prod[63:0];
            mstart = 1'b1; mcand = {32'd0, tmp_ff[31:0]}; mplier = {8'd0, invsep_ff};
            state_in = ST_FIN;
         end
         ST_CORDIC_START: begin
            ccmd.start = 1'b1;
            state_in = ST_CORDIC_RUN;
         end
         ST_CORDIC_RUN: if (cres.done) begin
            mstart = 1'b1; mcand = {32'd0, vmag}; mplier = {6'd0, sn_m};
            state_in = ST_MUL_XA;
         end
         ST_MUL_XA: if (mdone) begin
            mstart = 1'b1; mcand = 64'(prod[103:30]); mplier = {16'd0, dt};
            state_in = ST_MUL_XB;
         end
         ST_MUL_XB: if (mdone) begin
            x_in = sat_add(x_ff, 64'(prod[103:16]), vel_ff[31] != sn_ff[33]);
            mstart = 1'b1; mcand = {32'd0, vmag}; mplier = {6'd0, cs_m};
            state_in = ST_MUL_YA;
         end
         ST_MUL_YA: if (mdone) begin
            mstart = 1'b1; mcand = 64'(prod[103:30]); mplier = {16'd0, dt};
            state_in = ST_MUL_YB;
         end
         ST_MUL_YB: if (mdone) begin
            y_in = sat_add(y_ff, 64'(prod[103:16]), vel_ff[31] != cs_ff[33]);
            mstart = 1'b1;
            mcand = {32'd0, rate_ff[31] ? 32'(-rate_ff) : 32'(rate_ff)};
            mplier = {16'd0, dt};
            state_in = ST_YAW_A;
         end
         ST_YAW_A: if (mdone) begin
            tmp_in = prod[63:0];
            mstart = 1'b1; mcand = {32'd0, prod[31:0]}; mplier = {8'd0, InvTwoPiQ32};
            state_in = ST_YAW_B;
         end
         ST_YAW_B: if (mdone) begin
            hold_in = prod[63:32];
            mstart = 1'b1; mcand = {32'd0, tmp_ff[63:32]}; mplier = {8'd0, InvTwoPiQ32};
            state_in = ST_YAW_C;
         end
         ST_YAW_C: if (mdone) begin
            rr = 64'(prod[31:0] + hold_ff);
            yaw_in = rate_ff[31] ? yaw_ff - rr[31:0] : yaw_ff + rr[31:0];
            cnt_in = cnt_ff + 1'b1;
            out_load = 1'b1;
            state_in = ST_OUT;
         end
         ST_FIN: if (mdone) begin
            if (tmp_ff >= 64'h8000) rr = 64'h100000000;
            else rr = (tmp_ff << 16) + 64'(prod[63:16]);
            rate_in = sat_mag(rr, diff_w[16]);
            out_load = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: if (!rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         scale_ff <= '0;
         invsep_ff <= InvSepReset;
         x_ff <= '0; y_ff <= '0; yaw_ff <= '0;
         vel_ff <= VelReset; rate_ff <= RateReset; cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write && csr_index == REG_DISTANCE_SCALE) scale_ff <= csr_data;
         if (csr_write && csr_index == REG_INV_SEPARATION) invsep_ff <= csr_data;
         x_ff <= x_in; y_ff <= y_in; yaw_ff <= yaw_in;
         vel_ff <= vel_in; rate_ff <= rate_in; cnt_ff <= cnt_in;
      end
      num_ff <= num_in;
      tmp_ff <= tmp_in;
      hold_ff <= hold_in;
      if (accept) item_ff <= req_data;
      if (cres.done) begin
         sn_ff <= cres.sin_val;
         cs_ff <= cres.cos_val;
      end
      if (out_load) begin
         out_ff.pos_x <= x_in;
         out_ff.pos_y <= y_in;
         out_ff.heading <= yaw_in;
         out_ff.forward_velocity <= vel_in;
         out_ff.turn_rate <= rate_in;
         out_ff.step_number <= num_ff;
      end
   end

   `ASSERT_CLK(a_out_holds, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)
   `ASSERT_CLK(a_no_accept_busy, clock, reset, rsp_valid |-> req_stall)
   `ASSERT_CLK(a_count_step, clock, reset, cnt_ff != $past(cnt_ff) |-> $past(state_ff) == ST_YAW_C)

endmodule

@@ test/ddo_checker.sv @@
module ddo_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  ddo_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  ddo_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic             csr_index,
   input  logic [31:0]      csr_data,
   output int               fail_count,
   output int               outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import ddo_pkg::*;

   logic [31:0] scale_reg, inv_sep_reg;
   longint      pose_x, pose_y, speed, spin_rate;
   logic [31:0] yaw, steps;
   rsp_type     pose_q[$];

   function automatic logic [63:0] magn(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint clamp_mag(logic [63:0] m, logic neg);
      if (m > (64'd1 << 40)) m = 64'd1 << 40;
      return clamp32(neg ? -longint'(m) : longint'(m));
   endfunction

   // rotation-mode sine/cosine, Q2.30
   task automatic sin_cos(input logic [31:0] a, output longint sn, output longint cs);
      logic   flip;
      longint x, y, z, xs, ys;
      flip = a[30] ^ a[31];
      x = longint'(CordicStart);
      y = 0;
      if (flip) a = a + 32'h8000_0000;
      z = longint'(signed'(a));
      for (int i = 0; i < CordicSteps && i < AngleTableLen; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - longint'(atan_entry(5'(i)));
         end else begin
            x = x + ys; y = y - xs; z = z + longint'(atan_entry(5'(i)));
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      sn = y;
      cs = x;
   endtask

   function automatic longint travel(longint v, longint trig, logic [63:0] dt);
      logic [63:0] p;
      p = (magn(v) * magn(trig)) >> 30;
      p = (p * dt) >> 16;
      return ((v < 0) != (trig < 0)) ? -longint'(p) : longint'(p);
   endfunction

   task automatic odometry_step(input req_type r, output rsp_type o);
      longint      l, rt, sum, diff, sn, cs;
      logic [63:0] m, t, hi, lo, rr, dt, a, ah, al;
      logic [31:0] turn;
      o.step_number = steps;
      if (r.operation == OP_ENCODER) begin
         l = longint'(r.left_ticks);
         rt = longint'(r.right_ticks);
         sum = l + rt;
         diff = rt - l;
         m = (magn(sum) * 64'(scale_reg)) >> 1;
         t = magn(diff) * 64'(scale_reg);
         hi = t >> 32;
         lo = t & 64'hFFFF_FFFF;
         speed = clamp_mag(m, sum < 0);
         if (hi * 64'(inv_sep_reg) >= (64'd1 << 15)) rr = 64'd1 << 32;
         else rr = ((hi * 64'(inv_sep_reg)) << 16) + ((lo * 64'(inv_sep_reg)) >> 16);
         spin_rate = clamp_mag(rr, diff < 0);
      end else begin
         // first step after a zero counter integrates nothing
         dt = (steps == 0) ? 64'd0 : 64'(r.elapsed_time);
         sin_cos(yaw, sn, cs);
         pose_x = clamp32(pose_x + travel(speed, sn, dt));
         pose_y = clamp32(pose_y + travel(speed, cs, dt));
         a = magn(spin_rate) * dt;
         ah = a >> 32;
         al = a & 64'hFFFF_FFFF;
         turn = 32'((ah * 64'(InvTwoPiQ32)) + ((al * 64'(InvTwoPiQ32)) >> 32));
         if (spin_rate < 0) turn = -turn;
         yaw = yaw + turn;
         steps = steps + 1;
      end
      o.pos_x = pose_x[31:0];
      o.pos_y = pose_y[31:0];
      o.heading = yaw;
      o.forward_velocity = speed[31:0];
      o.turn_rate = spin_rate[31:0];
   endtask

   task automatic mismatch(string field, logic [31:0] want, logic [31:0] got);
      if (fail_count < 10)
         $display("mismatch %s: expected %h actual %h", field, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         scale_reg = 0;
         inv_sep_reg = InvSepReset;
         pose_x = 0; pose_y = 0; yaw = 0; steps = 0;
         speed = longint'(VelReset);
         spin_rate = longint'(RateReset);
         pose_q.delete();
         fail_count = 0;
      end else begin
         if (csr_write) begin
            if (csr_index == REG_DISTANCE_SCALE) scale_reg = csr_data;
            else inv_sep_reg = csr_data;
         end
         if (req_valid && !req_stall) begin
            odometry_step(req_data, want);
            pose_q.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pose_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected transaction on result channel");
               fail_count++;
            end else begin
               want = pose_q.pop_front();
               if (rsp_data.pos_x != want.pos_x) mismatch("pos_x", want.pos_x, rsp_data.pos_x);
               if (rsp_data.pos_y != want.pos_y) mismatch("pos_y", want.pos_y, rsp_data.pos_y);
               if (rsp_data.heading != want.heading)
                  mismatch("heading", want.heading, rsp_data.heading);
               if (rsp_data.forward_velocity != want.forward_velocity)
                  mismatch("forward_velocity", want.forward_velocity,
                           rsp_data.forward_velocity);
               if (rsp_data.turn_rate != want.turn_rate)
                  mismatch("turn_rate", want.turn_rate, rsp_data.turn_rate);
               if (rsp_data.step_number != want.step_number)
                  mismatch("step_number", want.step_number, rsp_data.step_number);
            end
         end
      end
      outstanding = pose_q.size();
   end
endmodule

@@ test/diff_drive_odometry_core_tb.sv @@
module diff_drive_odometry_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ddo_pkg::*;

   localparam int WatchdogLimit = 20000;
   localparam int DrainCycles = 300;

   logic        clock, reset;
   logic        req_valid, req_stall, rsp_valid, rsp_stall;
   req_type     req_data;
   rsp_type     rsp_data;
   logic        csr_write, csr_index;
   logic [31:0] csr_data;
   int          fail_count, outstanding;
   int          quiet_cycles;
   logic        no_idle;

   diff_drive_odometry_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data));

   ddo_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .outstanding(outstanding));

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 40);
   endfunction

   // receiver backpressure: mostly short stalls, a few long
   int stall_hold;
   always @(posedge clock) begin
      if (reset || no_idle) begin
         rsp_stall <= 1'b0;
         stall_hold <= 0;
      end else if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         int r;
         r = $urandom_range(0, 99);
         if (r < 60) begin
            rsp_stall <= 1'b0; stall_hold <= $urandom_range(0, 8);
         end else if (r < 92) begin
            rsp_stall <= 1'b1; stall_hold <= $urandom_range(0, 3);
         end else begin
            rsp_stall <= 1'b1; stall_hold <= $urandom_range(20, 60);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send(input req_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_encoder(input logic [15:0] l, input logic [15:0] r);
      req_type t;
      t.operation = OP_ENCODER;
      t.left_ticks = l;
      t.right_ticks = r;
      t.elapsed_time = 24'($urandom());
      send(t);
   endtask

   task automatic send_integrate(input logic [23:0] dt);
      req_type t;
      t.operation = OP_INTEGRATE;
      t.left_ticks = 16'($urandom());
      t.right_ticks = 16'($urandom());
      t.elapsed_time = dt;
      send(t);
   endtask

   // settle, then write both registers while idle
   task automatic program_regs(input logic [31:0] scale, input logic [31:0] inv_sep);
      req_valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= REG_DISTANCE_SCALE;
      csr_data <= scale;
      @(posedge clock);
      csr_index <= REG_INV_SEPARATION;
      csr_data <= inv_sep;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic random_items(input int count);
      int k;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(0, 9);
         if (k < 2) send_encoder(16'($urandom()), 16'($urandom()));
         else if (k < 5)
            send_encoder(16'($urandom_range(0, 400) - 200), 16'($urandom_range(0, 400) - 200));
         else if (k < 8) send_integrate(24'($urandom_range(0, 20000)));
         else send_integrate(24'($urandom()));
      end
   endtask

   initial begin
      logic [31:0] scales [6];
      logic [31:0] seps [6];
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_index = REG_DISTANCE_SCALE;
      csr_data = '0;
      no_idle = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset defaults first: zero-dt first step, then reset velocities
      send_integrate(24'hFFFFFF);
      send_integrate(24'h010000);
      send_encoder(16'sd100, 16'sd50);
      send_integrate(24'h008000);

      program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_encoder(16'h7FFF, 16'h7FFF);
      send_integrate(24'hFFFFFF);
      send_integrate(24'hFFFFFF);
      send_encoder(16'h8000, 16'h8000);
      send_encoder(16'h8000, 16'h7FFF);
      send_encoder(16'h7FFF, 16'h8000);
      send_integrate(24'hFFFFFF);
      send_integrate(24'h000000);
      send_encoder(16'h0000, 16'h0000);
      send_integrate(24'h000001);

      program_regs(32'd1, 32'd0);
      send_encoder(16'h0001, 16'hFFFF);
      send_encoder(16'h8000, 16'h7FFF);
      send_integrate(24'h123456);

      scales = '{32'd1092, 32'hFFFF_FFFF, 32'd0, 32'd65536, 32'h0001_0000, 32'h00FF_FFFF};
      seps = '{32'd145635, 32'd0, 32'hFFFF_FFFF, 32'd65536, 32'd300000, 32'd12345};
      for (int ph = 0; ph < 6; ph++) begin
         program_regs(scales[ph], seps[ph]);
         no_idle = (ph == 3);
         random_items(190);
      end
      req_valid <= 1'b0;
      no_idle = 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
